/* rtl/core/mapps_pkg.sv */
// Shared constants, types and helper functions for the multi-antenna power peak search core.
package mapps_pkg;

  // Field widths
  localparam int SAMPLE_W   = 16;
  localparam int HSQ_W      = 30;   // floor(s*s/2) of a 16-bit signed sample
  localparam int POWER_W    = 33;
  localparam int INDEX_W    = 14;
  localparam int LEN_W      = 15;   // search length, up to MAX_SEARCH_LENGTH
  localparam int OFFSET_W   = 15;
  localparam int SYNC_W     = 11;
  localparam int OFF_CALC_W = 18;   // headroom for the offset arithmetic

  // Configuration register widths
  localparam int FFT_W      = 13;
  localparam int OSL_W      = 2;
  localparam int PREFIX_W   = 11;
  localparam int ANTS_W     = 3;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  // Antenna lanes carried on the input word
  localparam int MAX_ANTENNAS = 4;
  localparam int NUM_LANES    = 2 * MAX_ANTENNAS;

  // Stream word widths
  localparam int IN_DATA_W  = NUM_LANES * SAMPLE_W;
  localparam int OUT_BITS   = INDEX_W + POWER_W + OFFSET_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Output word field positions
  localparam int OUT_IDX_LSB = 0;
  localparam int OUT_PWR_LSB = INDEX_W;
  localparam int OUT_OFF_LSB = INDEX_W + POWER_W;

  localparam int MAX_SEARCH_LENGTH = 16384;
  localparam int SYNC_SHIFT        = 3;   // sync position is prefix / 8

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FFT_SIZE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OVERSAMPLE_LOG2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PREFIX_SAMPLES  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANTENNAS_IN_USE = 2'd3;

  // Register reset values
  localparam logic [FFT_W-1:0]    FFT_SIZE_RST        = 13'd2048;
  localparam logic [OSL_W-1:0]    OVERSAMPLE_LOG2_RST = 2'd0;
  localparam logic [PREFIX_W-1:0] PREFIX_SAMPLES_RST  = 11'd144;
  localparam logic [ANTS_W-1:0]   ANTENNAS_IN_USE_RST = 3'd1;

  // Settings derived from the configuration registers
  typedef struct packed {
    logic [LEN_W-1:0]   len;
    logic [INDEX_W-1:0] half_len;
    logic [SYNC_W-1:0]  sync;
    logic [ANTS_W-1:0]  ants;
  } cfg_t;

  // Tracker state seen from outside the peak stage
  typedef struct packed {
    logic [INDEX_W-1:0] count;
    logic [POWER_W-1:0] best_power;
  } peak_stat_t;

  // fft_size << oversample_log2, saturated, with zero taken as one
  function automatic logic [LEN_W-1:0] search_len(input logic [FFT_W-1:0] fft,
                                                  input logic [OSL_W-1:0] osl);
    logic [FFT_W+2:0] wide;
    logic [LEN_W-1:0] len;
    wide = (FFT_W + 3)'(fft) << osl;
    if (wide > (FFT_W + 3)'(MAX_SEARCH_LENGTH)) begin
      len = LEN_W'(MAX_SEARCH_LENGTH);
    end else if (wide == '0) begin
      len = LEN_W'(1);
    end else begin
      len = wide[LEN_W-1:0];
    end
    return len;
  endfunction

  // (prefix / 8) << oversample_log2
  function automatic logic [SYNC_W-1:0] scaled_sync(input logic [PREFIX_W-1:0] prefix,
                                                    input logic [OSL_W-1:0] osl);
    logic [SYNC_W-1:0] base;
    base = SYNC_W'(prefix >> SYNC_SHIFT);
    return base << osl;
  endfunction

endpackage

/* rtl/core/mapps_power.sv */
// Power front end: input register, per-lane half squares, masked antenna sum.
module mapps_power (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [mapps_pkg::IN_DATA_W-1:0]  in_data,
  input  logic [mapps_pkg::ANTS_W-1:0]     ants,
  output logic                             sum_valid,
  input  logic                             sum_ready,
  output logic [mapps_pkg::POWER_W-1:0]    sum_power
);

  logic                              s1_v_r;
  logic [mapps_pkg::IN_DATA_W-1:0]   s1_data_r;
  logic                              s2_v_r;
  logic [mapps_pkg::HSQ_W-1:0]       s2_hsq_r [mapps_pkg::NUM_LANES];
  logic                              s3_v_r;
  logic [mapps_pkg::POWER_W-1:0]     s3_pwr_r;

  logic [mapps_pkg::HSQ_W-1:0]       hsq_nxt [mapps_pkg::NUM_LANES];
  logic [mapps_pkg::POWER_W-1:0]     pwr_nxt;
  logic signed [2*mapps_pkg::SAMPLE_W-1:0] prod [mapps_pkg::NUM_LANES];

  logic rdy1, rdy2, rdy3;

  // Advance each stage when it is empty or the next one moves
  assign rdy3 = !s3_v_r || sum_ready;
  assign rdy2 = !s2_v_r || rdy3;
  assign rdy1 = !s1_v_r || rdy2;

  assign in_ready  = rdy1;
  assign sum_valid = s3_v_r;
  assign sum_power = s3_pwr_r;

  always_comb begin
    for (int k = 0; k < mapps_pkg::NUM_LANES; k++) begin
      prod[k] = $signed(s1_data_r[k*mapps_pkg::SAMPLE_W +: mapps_pkg::SAMPLE_W]) *
                $signed(s1_data_r[k*mapps_pkg::SAMPLE_W +: mapps_pkg::SAMPLE_W]);
      hsq_nxt[k] = prod[k][mapps_pkg::HSQ_W:1];
    end
  end

  // Drop lanes of antennas beyond the count in use
  always_comb begin
    pwr_nxt = '0;
    for (int k = 0; k < mapps_pkg::NUM_LANES; k++) begin
      if (ants > mapps_pkg::ANTS_W'(k >> 1)) begin
        pwr_nxt = pwr_nxt + mapps_pkg::POWER_W'(s2_hsq_r[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_v_r <= in_valid;
      end
      if (rdy2) begin
        s2_v_r <= s1_v_r;
      end
      if (rdy3) begin
        s3_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_data_r <= in_data;
    end
    if (rdy2 && s1_v_r) begin
      s2_hsq_r <= hsq_nxt;
    end
    if (rdy3 && s2_v_r) begin
      s3_pwr_r <= pwr_nxt;
    end
  end

endmodule

/* rtl/core/mapps_peak.sv */
// Peak tracker: first strict maximum, search length count, offset and result register.
module mapps_peak (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             pwr_valid,
  output logic                             pwr_ready,
  input  logic [mapps_pkg::POWER_W-1:0]    pwr,
  input  mapps_pkg::cfg_t                  cfg,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mapps_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                             res_load,
  output mapps_pkg::peak_stat_t            stat
);

  logic [mapps_pkg::INDEX_W-1:0]    count_r;
  logic [mapps_pkg::POWER_W-1:0]    best_power_r;
  logic [mapps_pkg::INDEX_W-1:0]    best_index_r;
  logic                             out_valid_r;
  logic [mapps_pkg::OUT_DATA_W-1:0] out_data_r;

  logic                             take;
  logic                             better;
  logic                             last;
  logic [mapps_pkg::POWER_W-1:0]    power_nxt;
  logic [mapps_pkg::INDEX_W-1:0]    index_nxt;
  logic [mapps_pkg::OFFSET_W-1:0]   off_cur;
  logic [mapps_pkg::OFFSET_W-1:0]   off_keep;
  logic [mapps_pkg::OFFSET_W-1:0]   offset_nxt;

  // Wrap the index to negative above half the length, then subtract the sync position
  function automatic logic [mapps_pkg::OFFSET_W-1:0] wrap_offset(
      input logic [mapps_pkg::INDEX_W-1:0] idx,
      input mapps_pkg::cfg_t               c);
    logic signed [mapps_pkg::OFF_CALC_W-1:0] v;
    v = $signed(mapps_pkg::OFF_CALC_W'(idx));
    if (idx > c.half_len) begin
      v = v - $signed(mapps_pkg::OFF_CALC_W'(c.len));
    end
    v = v - $signed(mapps_pkg::OFF_CALC_W'(c.sync));
    return v[mapps_pkg::OFFSET_W-1:0];
  endfunction

  assign pwr_ready = !out_valid_r || out_tready;
  assign take      = pwr_valid && pwr_ready;
  assign better    = pwr > best_power_r;
  assign last      = (mapps_pkg::LEN_W'(count_r) + mapps_pkg::LEN_W'(1)) >= cfg.len;
  assign res_load  = take && last;

  assign power_nxt = better ? pwr : best_power_r;
  assign index_nxt = better ? count_r : best_index_r;

  // Both candidates ahead of the compare keep the path short
  assign off_cur    = wrap_offset(count_r, cfg);
  assign off_keep   = wrap_offset(best_index_r, cfg);
  assign offset_nxt = better ? off_cur : off_keep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      best_power_r <= '0;
      best_index_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (take) begin
        if (last) begin
          count_r      <= '0;
          best_power_r <= '0;
          best_index_r <= '0;
        end else begin
          count_r      <= count_r + mapps_pkg::INDEX_W'(1);
          best_power_r <= power_nxt;
          best_index_r <= index_nxt;
        end
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r <= mapps_pkg::OUT_DATA_W'({offset_nxt, power_nxt, index_nxt});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign stat       = '{count: count_r, best_power: best_power_r};

endmodule

/* rtl/core/multi_antenna_power_peak_search_core.sv */
// Top level of the multi-antenna power peak search core (timing estimator).
//
//   channel | direction | handshake             | word contents
//   --------+-----------+-----------------------+---------------------------------------
//   in_     | sink      | in_tvalid/in_tready   | 8 x 16-bit signed I/Q, antennas 0..3
//   out_    | source    | out_tvalid/out_tready | peak_index, peak_power, peak_offset
//   cfg_    | sink      | cfg_we                | index 0..3, up to 13 data bits
//
// One word is taken per cycle when the output side keeps up. A sample passes an
// input register, a squaring stage, a summing stage and the peak tracker; the result
// word is registered when the peak tracker takes the last sample of a search.
// Reset (rst_n low, synchronous) empties the pipe, clears the tracker and loads
// the register defaults. A stall on out_tready holds the result word and backs
// up stage by stage to in_tready; nothing is dropped.
module multi_antenna_power_peak_search_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // re_ant0, im_ant0, re_ant1, im_ant1, re_ant2, im_ant2, re_ant3, im_ant3
  input  logic [mapps_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // peak_index[13:0], peak_power[46:14], peak_offset[61:47], zero pad[63:62]
  output logic [mapps_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic                                  cfg_we,
  input  logic [mapps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mapps_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Configuration registers
  logic [mapps_pkg::FFT_W-1:0]    fft_size_r;
  logic [mapps_pkg::OSL_W-1:0]    oversample_log2_r;
  logic [mapps_pkg::PREFIX_W-1:0] prefix_samples_r;
  logic [mapps_pkg::ANTS_W-1:0]   antennas_in_use_r;

  mapps_pkg::cfg_t       cfg;
  mapps_pkg::peak_stat_t stat;

  logic                          sum_valid;
  logic                          sum_ready;
  logic [mapps_pkg::POWER_W-1:0] sum_power;
  logic                          res_load;

  // Take a register write at once; the user must write only while no word is in the pipe (not enforced here)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fft_size_r        <= mapps_pkg::FFT_SIZE_RST;
      oversample_log2_r <= mapps_pkg::OVERSAMPLE_LOG2_RST;
      prefix_samples_r  <= mapps_pkg::PREFIX_SAMPLES_RST;
      antennas_in_use_r <= mapps_pkg::ANTENNAS_IN_USE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mapps_pkg::REG_FFT_SIZE:        fft_size_r        <= cfg_data[mapps_pkg::FFT_W-1:0];
        mapps_pkg::REG_OVERSAMPLE_LOG2: oversample_log2_r <= cfg_data[mapps_pkg::OSL_W-1:0];
        mapps_pkg::REG_PREFIX_SAMPLES:  prefix_samples_r  <= cfg_data[mapps_pkg::PREFIX_W-1:0];
        mapps_pkg::REG_ANTENNAS_IN_USE: antennas_in_use_r <= cfg_data[mapps_pkg::ANTS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Derive the search length, its half and the scaled sync position
  always_comb begin
    cfg.len      = mapps_pkg::search_len(fft_size_r, oversample_log2_r);
    cfg.half_len = cfg.len[mapps_pkg::LEN_W-1:1];
    cfg.sync     = mapps_pkg::scaled_sync(prefix_samples_r, oversample_log2_r);
    cfg.ants     = antennas_in_use_r;
  end

  // Square and sum the active antennas
  mapps_power u_power (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_tdata),
    .ants      (cfg.ants),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum_power (sum_power)
  );

  // Track the first strict maximum and emit one word per search
  mapps_peak u_peak (
    .clk        (clk),
    .rst_n      (rst_n),
    .pwr_valid  (sum_valid),
    .pwr_ready  (sum_ready),
    .pwr        (sum_power),
    .cfg        (cfg),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .res_load   (res_load),
    .stat       (stat)
  );

  // Input backpressure only comes from a full pipe behind a stalled output
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("in_tready low without a stalled result word");

  // A finished search leaves the tracker cleared
  a_search_restart: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> (stat.count == '0 && stat.best_power == '0))
    else $error("tracker not cleared after a result");

  // An all-zero search reports index zero
  a_zero_power_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid &&
     out_tdata[mapps_pkg::OUT_PWR_LSB +: mapps_pkg::POWER_W] == '0) |->
    (out_tdata[mapps_pkg::OUT_IDX_LSB +: mapps_pkg::INDEX_W] == '0))
    else $error("zero peak power with nonzero peak index");

endmodule
